### rtl/core/egcd_pkg.sv
`timescale 1ns / 1ps

package egcd_pkg;

  localparam int VALUE_BITS_DEF = 31;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } gcd_state_t;

endpackage

### rtl/core/euclid_gcd_unit.sv
`timescale 1ns / 1ps

// Greatest common divisor of two unsigned VALUE_BITS-wide operands; if one
// operand is zero the other is returned, so gcd(0,0) is 0. An item is taken
// when start is high and busy is low; busy then stays high until the answer
// appears on divisor with done high for exactly one cycle, and there is no
// way to hold the answer off, so the receiver must take it in that cycle.
// One binary-GCD step (halve an even operand, or subtract the smaller odd
// operand from the larger and halve) runs per cycle on a single shared
// compare and subtract unit. Every step removes at least one bit from the
// operands, so the steps of an item are bounded by the operand bits, and are
// fewer for most operands. busy falls in the cycle done is shown, so a new
// item can start then.
module euclid_gcd_unit #(
  parameter int VALUE_BITS = egcd_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] operand_a,
  input  logic [VALUE_BITS-1:0] operand_b,
  output logic                  done,
  output logic [VALUE_BITS-1:0] divisor
);

  localparam int KW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  egcd_pkg::gcd_state_t state, state_next;

  logic [VALUE_BITS-1:0] a, a_next;
  logic [VALUE_BITS-1:0] b, b_next;
  logic [KW-1:0]         k, k_next;
  logic [VALUE_BITS-1:0] divisor_next;
  logic                  done_next;

  logic                  a_ge_b;
  logic [VALUE_BITS-1:0] big, little, diff, odd_part;

  // shared compare / subtract
  assign a_ge_b   = (a >= b);
  assign big      = a_ge_b ? a : b;
  assign little   = a_ge_b ? b : a;
  assign diff     = big - little;
  assign odd_part = (a == '0) ? b : a;

  assign busy = (state != egcd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egcd_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    a       <= a_next;
    b       <= b_next;
    k       <= k_next;
    divisor <= divisor_next;
  end

  always_comb begin
    state_next   = state;
    a_next       = a;
    b_next       = b;
    k_next       = k;
    divisor_next = divisor;
    done_next    = 1'b0;
    unique case (state)
      egcd_pkg::ST_IDLE: begin
        if (start) begin
          a_next     = operand_a;
          b_next     = operand_b;
          k_next     = '0;
          state_next = egcd_pkg::ST_RUN;
        end
      end
      egcd_pkg::ST_RUN: begin
        if (a == '0 || b == '0) begin
          divisor_next = odd_part << k;
          done_next    = 1'b1;
          state_next   = egcd_pkg::ST_IDLE;
        end else if (!a[0] && !b[0]) begin
          a_next = a >> 1;
          b_next = b >> 1;
          k_next = k + KW'(1);
        end else if (!a[0]) begin
          a_next = a >> 1;
        end else if (!b[0]) begin
          b_next = b >> 1;
        end else if (a_ge_b) begin
          a_next = diff >> 1;
        end else begin
          b_next = diff >> 1;
        end
      end
      default: begin
        state_next = egcd_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == egcd_pkg::ST_RUN))
    else $error("done without a running item");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == egcd_pkg::ST_RUN) |-> (int'(k) < VALUE_BITS))
    else $error("common power of two out of range");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int VALUE_BITS = egcd_pkg::VALUE_BITS_DEF;
  localparam logic [VALUE_BITS-1:0] MAX_VAL = {VALUE_BITS{1'b1}};

  typedef struct {
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b;
    int unsigned           gap;
  } gcd_pair_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [VALUE_BITS-1:0] operand_a = '0;
  logic [VALUE_BITS-1:0] operand_b = '0;
  logic                  done;
  logic [VALUE_BITS-1:0] divisor;

  gcd_pair_t             pending_pairs[$];
  logic [VALUE_BITS-1:0] expected_divisors[$];
  gcd_pair_t             cur_pair;
  logic                  pair_loaded = 1'b0;
  int unsigned           gap_left = 0;
  logic                  taken = 1'b0;
  int unsigned           accepted_count = 0;
  int unsigned           pair_count = 0;
  int unsigned           error_count = 0;

  euclid_gcd_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .done      (done),
    .divisor   (divisor)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [VALUE_BITS-1:0] gcd_expected(input logic [VALUE_BITS-1:0] x_in,
                                                         input logic [VALUE_BITS-1:0] y_in);
    logic [VALUE_BITS-1:0] x;
    logic [VALUE_BITS-1:0] y;
    x = x_in;
    y = y_in;
    while (x != 0 && y != 0) begin
      if (x > y) x = x % y;
      else y = y % x;
    end
    return (x == 0) ? y : x;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  // bursts with no gap every fourth block of 64 items
  task automatic add_pair(input logic [VALUE_BITS-1:0] a, input logic [VALUE_BITS-1:0] b);
    gcd_pair_t p;
    p.a = a;
    p.b = b;
    p.gap = (((pair_count / 64) % 4) == 2) ? 0 : $urandom_range(0, 18);
    pending_pairs = {pending_pairs, p};
    pair_count++;
  endtask

  // driver: one NBA per signal per falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      pair_loaded = 1'b0;
      gap_left = 0;
    end else begin
      if (start && taken) pair_loaded = 1'b0;
      if (!pair_loaded && pending_pairs.size() != 0) begin
        cur_pair = pending_pairs.pop_front();
        pair_loaded = 1'b1;
        gap_left = cur_pair.gap;
      end
      if (pair_loaded && gap_left == 0) begin
        start <= 1'b1;
        operand_a <= cur_pair.a;
        operand_b <= cur_pair.b;
      end else begin
        start <= 1'b0;
        if (pair_loaded) gap_left--;
      end
    end
  end

  // monitor: retire results first, then record the item taken at this edge
  always @(posedge clk) begin
    logic [VALUE_BITS-1:0] want;
    taken <= start && !busy && !rst;
    if (!rst && done) begin
      if (expected_divisors.size() == 0) begin
        report_mismatch($sformatf("divisor %0d with no item pending", divisor));
      end else begin
        want = expected_divisors.pop_front();
        if (divisor !== want)
          report_mismatch($sformatf("divisor got %0d want %0d", divisor, want));
      end
    end
    if (!rst && start && !busy) begin
      expected_divisors = {expected_divisors, gcd_expected(operand_a, operand_b)};
      accepted_count++;
    end
  end

  initial begin
    int unsigned           kind;
    int unsigned           g;
    int unsigned           total;
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b;

    // zero operands, extremes, equal values, powers of two, worst-case Fibonacci pair
    add_pair(0, 0);
    add_pair(0, MAX_VAL);
    add_pair(MAX_VAL, 0);
    add_pair(0, 1);
    add_pair(1, 0);
    add_pair(MAX_VAL, MAX_VAL);
    add_pair(1, MAX_VAL);
    add_pair(MAX_VAL, 1);
    add_pair(MAX_VAL, MAX_VAL - 1'b1);
    add_pair(1, 1);
    add_pair(12345, 12345);
    add_pair(31'h4000_0000, 31'h4000_0000);
    add_pair(31'h4000_0000, 31'h2000_0000);
    add_pair(31'h4000_0000, 31'h0030_0000);
    add_pair(31'h5555_5555, 31'h2AAA_AAAA);
    add_pair(1134903170, 1836311903);
    add_pair(1836311903, 1134903170);
    add_pair(12, 18);
    add_pair(7, 13);
    add_pair(2147483629, 2147483587);
    add_pair(MAX_VAL, VALUE_BITS'(3 * 7 * 11));

    for (int i = 0; i < 1300; i++) begin
      kind = $urandom_range(0, 9);
      case (kind) inside
        [0:2]: begin
          a = VALUE_BITS'($urandom());
          b = VALUE_BITS'($urandom());
        end
        [3:5]: begin
          g = $urandom_range(1, 65535);
          a = VALUE_BITS'(g * $urandom_range(0, 32767));
          b = VALUE_BITS'(g * $urandom_range(0, 32767));
        end
        6: begin
          a = VALUE_BITS'($urandom());
          b = '0;
          if ($urandom_range(0, 1)) begin
            b = a;
            a = '0;
          end
        end
        7: begin
          a = VALUE_BITS'($urandom());
          b = $urandom_range(0, 1) ? a : (a >> $urandom_range(0, 30));
        end
        8: begin
          a = VALUE_BITS'($urandom_range(0, 255));
          b = VALUE_BITS'($urandom_range(0, 255));
        end
        default: begin
          a = VALUE_BITS'($urandom_range(1, 255) << $urandom_range(0, 23));
          b = VALUE_BITS'($urandom_range(1, 255) << $urandom_range(0, 23));
        end
      endcase
      add_pair(a, b);
    end
    total = pending_pairs.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (accepted_count < total) @(posedge clk);
    while (expected_divisors.size() != 0) @(posedge clk);
    repeat (2 * VALUE_BITS + 8) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/egcd_pkg.sv
rtl/core/euclid_gcd_unit.sv
tb/sv/tb_top.sv
